// ===== rtl/amts_pkg.sv =====
// ----------------------------------------------------------------------------
// Auxiliary motor trajectory sequencer package
// Shared codes, reset values and the word types that pass between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package amts_pkg;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_SPEED      = 3'd1,
    ACT_GOTO       = 3'd2,
    ACT_CLAMP      = 3'd3,
    ACT_FIND_ZERO  = 3'd4,
    ACT_FIND_LIMIT = 3'd5,
    ACT_ENCODER    = 3'd6
  } action_t;

  typedef enum logic [3:0] {
    TRAJ_DONE      = 4'd0,
    TRAJ_SPEED     = 4'd1,
    TRAJ_GOTO      = 4'd2,
    TRAJ_UNBLOCK   = 4'd3,
    TRAJ_CLAMP     = 4'd4,
    TRAJ_ZERO_SEEK = 4'd5,
    TRAJ_ZERO_ON   = 4'd6,
    TRAJ_LIMIT     = 4'd7,
    TRAJ_SETTLE    = 4'd8
  } traj_mode_t;

  typedef enum logic [2:0] {
    MODE_NONE      = 3'd0,
    MODE_TRAJ      = 3'd1,
    MODE_TRAJ_BLK  = 3'd2,
    MODE_TRAJ_ONLY = 3'd3,
    MODE_OFF       = 3'd4
  } mode_cmd_t;

  typedef enum logic [1:0] {
    POS_NONE   = 2'd0,
    POS_OFFSET = 2'd1,
    POS_ABS    = 2'd2
  } pos_kind_t;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] CFG_BLK_DETECT_EN      = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_UNBLOCK_BACKOFF    = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_UNBLOCK_TICKS      = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_DONE_TOLERANCE     = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_LIMIT_SETTLE_TICKS = 3'd4;

  localparam logic        RST_BLK_DETECT_EN      = 1'b0;
  localparam logic [14:0] RST_UNBLOCK_BACKOFF    = 15'd250;
  localparam logic [9:0]  RST_UNBLOCK_TICKS      = 10'd112;
  localparam logic [15:0] RST_DONE_TOLERANCE     = 16'd300;
  localparam logic [9:0]  RST_LIMIT_SETTLE_TICKS = 10'd675;

  typedef struct packed {
    logic        blk_detect_en;
    logic [14:0] unblock_backoff;
    logic [9:0]  unblock_ticks;
    logic [15:0] done_tolerance;
    logic [9:0]  limit_settle_ticks;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] encoder_diff;
    logic [16:0] start_value;
    logic [7:0]  speed;
    logic        blocked;
    logic        zero_contact;
    logic        traj_control_on;
    logic        speed_uses_pos;
    logic [31:0] speed_pos_target;
    logic [31:0] pos_target;
    logic [31:0] pos_current;
  } in_word_t;

  typedef struct packed {
    logic        speed_cmd_valid;
    logic [7:0]  speed_cmd;
    pos_kind_t   pos_cmd_kind;
    logic [31:0] pos_cmd_value;
    mode_cmd_t   mode_cmd;
    logic        finished;
    logic        pwm_cmd_valid;
    logic [15:0] pwm_cmd;
    traj_mode_t  traj_state;
    logic [15:0] motor_position;
  } res_word_t;

endpackage

`default_nettype wire

// ===== rtl/amts_cfg.sv =====
// ----------------------------------------------------------------------------
// Auxiliary motor trajectory sequencer configuration registers
// Holds the five settings, written one at a time through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module amts_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              wr_en,
  input  wire logic [amts_pkg::CfgIndexW-1:0]    wr_index,
  input  wire logic [amts_pkg::CfgDataW-1:0]     wr_data,
  output amts_pkg::cfg_t                         cfg
);

  amts_pkg::cfg_t cfg_r;
  amts_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        amts_pkg::CFG_BLK_DETECT_EN:      cfg_nxt.blk_detect_en      = wr_data[0];
        amts_pkg::CFG_UNBLOCK_BACKOFF:    cfg_nxt.unblock_backoff    = wr_data[14:0];
        amts_pkg::CFG_UNBLOCK_TICKS:      cfg_nxt.unblock_ticks      = wr_data[9:0];
        amts_pkg::CFG_DONE_TOLERANCE:     cfg_nxt.done_tolerance     = wr_data[15:0];
        amts_pkg::CFG_LIMIT_SETTLE_TICKS: cfg_nxt.limit_settle_ticks = wr_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blk_detect_en      <= amts_pkg::RST_BLK_DETECT_EN;
      cfg_r.unblock_backoff    <= amts_pkg::RST_UNBLOCK_BACKOFF;
      cfg_r.unblock_ticks      <= amts_pkg::RST_UNBLOCK_TICKS;
      cfg_r.done_tolerance     <= amts_pkg::RST_DONE_TOLERANCE;
      cfg_r.limit_settle_ticks <= amts_pkg::RST_LIMIT_SETTLE_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/amts_step.sv =====
// ----------------------------------------------------------------------------
// Auxiliary motor trajectory sequencer step logic
// Trajectory state registers, next-state logic and the result for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module amts_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire amts_pkg::in_word_t in_word,
  input  wire amts_pkg::cfg_t     cfg,
  output amts_pkg::res_word_t     res
);

  amts_pkg::traj_mode_t mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [9:0]  wait_r, wait_nxt;
  logic [31:0] target_r, target_nxt;
  logic [15:0] clamp_r, clamp_nxt;
  logic [15:0] rstpos_r, rstpos_nxt;

  logic [9:0]  wait_dec;
  logic        wait_done;
  logic [15:0] off16;
  logic [31:0] off32;
  logic [31:0] err;
  logic [31:0] err_mag;
  logic        goto_close;
  logic        speed_hit;
  logic        tick_on;

  assign wait_dec   = wait_r - 10'd1;
  assign wait_done  = (wait_dec == 10'd0);
  assign off16      = in_word.start_value[15:0] - pos_r;
  assign off32      = {{16{off16[15]}}, off16};
  assign err        = in_word.speed_pos_target - in_word.pos_current;
  assign err_mag    = err[31] ? (32'd0 - err) : err;
  assign goto_close = (err_mag < {16'd0, cfg.done_tolerance});
  assign speed_hit  = in_word.speed_uses_pos && (in_word.speed_pos_target == in_word.pos_target);
  assign tick_on    = in_word.traj_control_on;

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    wait_nxt   = wait_r;
    target_nxt = target_r;
    clamp_nxt  = clamp_r;
    rstpos_nxt = rstpos_r;
    unique case (in_word.action)
      amts_pkg::ACT_TICK: begin
        if (tick_on) begin
          unique case (mode_r)
            amts_pkg::TRAJ_SPEED: begin
              if (speed_hit) mode_nxt = amts_pkg::TRAJ_DONE;
            end
            amts_pkg::TRAJ_GOTO: begin
              if (in_word.blocked) begin
                mode_nxt = amts_pkg::TRAJ_UNBLOCK;
                wait_nxt = cfg.unblock_ticks;
              end else if (goto_close) begin
                mode_nxt = amts_pkg::TRAJ_DONE;
              end
            end
            amts_pkg::TRAJ_UNBLOCK: begin
              wait_nxt = wait_dec;
              if (wait_done) mode_nxt = amts_pkg::TRAJ_GOTO;
            end
            amts_pkg::TRAJ_CLAMP: begin
              if (in_word.blocked) mode_nxt = amts_pkg::TRAJ_DONE;
            end
            amts_pkg::TRAJ_ZERO_SEEK: begin
              if (in_word.zero_contact) mode_nxt = amts_pkg::TRAJ_ZERO_ON;
            end
            amts_pkg::TRAJ_ZERO_ON: begin
              if (!in_word.zero_contact) begin
                mode_nxt = amts_pkg::TRAJ_DONE;
                pos_nxt  = rstpos_r;
              end
            end
            amts_pkg::TRAJ_LIMIT: begin
              if (in_word.blocked) begin
                mode_nxt = amts_pkg::TRAJ_SETTLE;
                wait_nxt = cfg.limit_settle_ticks;
              end
            end
            amts_pkg::TRAJ_SETTLE: begin
              wait_nxt = wait_dec;
              if (wait_done) begin
                mode_nxt = amts_pkg::TRAJ_DONE;
                pos_nxt  = rstpos_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      amts_pkg::ACT_SPEED: mode_nxt = amts_pkg::TRAJ_SPEED;
      amts_pkg::ACT_GOTO: begin
        mode_nxt   = amts_pkg::TRAJ_GOTO;
        target_nxt = in_word.pos_current + off32;
      end
      amts_pkg::ACT_CLAMP: begin
        mode_nxt  = amts_pkg::TRAJ_CLAMP;
        clamp_nxt = in_word.start_value[15:0];
      end
      amts_pkg::ACT_FIND_ZERO: begin
        mode_nxt   = amts_pkg::TRAJ_ZERO_SEEK;
        rstpos_nxt = in_word.start_value[15:0];
      end
      amts_pkg::ACT_FIND_LIMIT: begin
        mode_nxt   = amts_pkg::TRAJ_LIMIT;
        rstpos_nxt = in_word.start_value[15:0];
      end
      amts_pkg::ACT_ENCODER: pos_nxt = pos_r + in_word.encoder_diff;
      default: begin
      end
    endcase
  end

  always_comb begin
    res                 = '0;
    res.pos_cmd_kind    = amts_pkg::POS_NONE;
    res.mode_cmd        = amts_pkg::MODE_NONE;
    res.traj_state      = mode_nxt;
    res.motor_position  = pos_nxt;
    unique case (in_word.action)
      amts_pkg::ACT_TICK: begin
        if (tick_on) begin
          unique case (mode_r)
            amts_pkg::TRAJ_SPEED: begin
              if (speed_hit) res.finished = 1'b1;
            end
            amts_pkg::TRAJ_GOTO: begin
              if (in_word.blocked) begin
                res.pos_cmd_kind  = amts_pkg::POS_OFFSET;
                res.pos_cmd_value = 32'd0 - {17'd0, cfg.unblock_backoff};
              end else if (goto_close) begin
                res.finished = 1'b1;
              end
            end
            amts_pkg::TRAJ_UNBLOCK: begin
              if (wait_done) begin
                res.pos_cmd_kind  = amts_pkg::POS_ABS;
                res.pos_cmd_value = target_r;
              end
            end
            amts_pkg::TRAJ_CLAMP: begin
              if (in_word.blocked) begin
                res.mode_cmd      = amts_pkg::MODE_OFF;
                res.finished      = 1'b1;
                res.pwm_cmd_valid = 1'b1;
                res.pwm_cmd       = clamp_r;
              end
            end
            amts_pkg::TRAJ_ZERO_ON: begin
              if (!in_word.zero_contact) begin
                res.speed_cmd_valid = 1'b1;
                res.finished        = 1'b1;
              end
            end
            amts_pkg::TRAJ_LIMIT: begin
              if (in_word.blocked) begin
                res.mode_cmd      = amts_pkg::MODE_TRAJ_ONLY;
                res.pwm_cmd_valid = 1'b1;
              end
            end
            amts_pkg::TRAJ_SETTLE: begin
              if (wait_done) begin
                res.mode_cmd = amts_pkg::MODE_OFF;
                res.finished = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      amts_pkg::ACT_SPEED: res.mode_cmd = amts_pkg::MODE_TRAJ;
      amts_pkg::ACT_GOTO: begin
        res.pos_cmd_kind  = amts_pkg::POS_OFFSET;
        res.pos_cmd_value = off32;
        res.mode_cmd      = cfg.blk_detect_en ? amts_pkg::MODE_TRAJ_BLK
                                              : amts_pkg::MODE_TRAJ;
      end
      amts_pkg::ACT_CLAMP: begin
        res.speed_cmd_valid = 1'b1;
        res.speed_cmd       = in_word.speed;
        res.mode_cmd        = amts_pkg::MODE_TRAJ_BLK;
      end
      amts_pkg::ACT_FIND_ZERO: begin
        res.speed_cmd_valid = 1'b1;
        res.speed_cmd       = in_word.speed;
        res.mode_cmd        = amts_pkg::MODE_TRAJ;
      end
      amts_pkg::ACT_FIND_LIMIT: begin
        res.speed_cmd_valid = 1'b1;
        res.speed_cmd       = in_word.speed;
        res.mode_cmd        = amts_pkg::MODE_TRAJ_BLK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= amts_pkg::TRAJ_DONE;
      pos_r    <= 16'd0;
      wait_r   <= 10'd0;
      target_r <= 32'd0;
      clamp_r  <= 16'd0;
      rstpos_r <= 16'd0;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      wait_r   <= wait_nxt;
      target_r <= target_nxt;
      clamp_r  <= clamp_nxt;
      rstpos_r <= rstpos_nxt;
    end
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(mode_r) && $stable(pos_r) && $stable(wait_r))
    else $error("trajectory state changed without a word");

  a_finished_done: assert property (@(posedge clk) disable iff (!rst_n)
    res.finished |-> res.traj_state == amts_pkg::TRAJ_DONE)
    else $error("finished reported while a trajectory is still active");

  a_pwm_mode: assert property (@(posedge clk) disable iff (!rst_n)
    res.pwm_cmd_valid |-> (res.mode_cmd == amts_pkg::MODE_OFF ||
                           res.mode_cmd == amts_pkg::MODE_TRAJ_ONLY))
    else $error("pwm command without a matching control mode");

  a_tick_off_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && in_word.action == amts_pkg::ACT_TICK && !in_word.traj_control_on)
      |=> $stable(mode_r) && $stable(pos_r))
    else $error("tick with control off changed the trajectory");

endmodule

`default_nettype wire

// ===== rtl/aux_motor_trajectory_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Auxiliary motor trajectory sequencer
// Top level: input word register, step logic and result word register.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the result port is not stalled
// and returns exactly one result word for each: the word is captured in an input
// register, processed combinationally by the step logic (the longest path is the
// goto error subtraction, magnitude and tolerance compare) and held in a result
// register that drives the result port. A new word can be accepted into an empty
// input register while a finished result waits. Configuration writes are always
// accepted and should only be issued while no word is in flight.
`default_nettype none

module aux_motor_trajectory_sequencer_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [amts_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [amts_pkg::CfgDataW-1:0]  cfg_data,

  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [2:0]                     in_action,
  input  wire logic signed [15:0]             in_encoder_diff,
  input  wire logic signed [16:0]             in_start_value,
  input  wire logic signed [7:0]              in_speed,
  input  wire logic                           in_blocked,
  input  wire logic                           in_zero_contact,
  input  wire logic                           in_traj_control_on,
  input  wire logic                           in_speed_uses_pos,
  input  wire logic signed [31:0]             in_speed_pos_target,
  input  wire logic signed [31:0]             in_pos_target,
  input  wire logic signed [31:0]             in_pos_current,

  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_speed_cmd_valid,
  output logic signed [7:0]                   out_speed_cmd,
  output logic [1:0]                          out_pos_cmd_kind,
  output logic signed [31:0]                  out_pos_cmd_value,
  output logic [2:0]                          out_mode_cmd,
  output logic                                out_finished,
  output logic                                out_pwm_cmd_valid,
  output logic signed [15:0]                  out_pwm_cmd,
  output logic [3:0]                          out_traj_state,
  output logic [15:0]                         out_motor_position
);

  amts_pkg::cfg_t      cfg;
  amts_pkg::in_word_t  in_r;
  amts_pkg::in_word_t  in_nxt;
  amts_pkg::res_word_t res;
  amts_pkg::res_word_t res_r;
  logic                in_valid_r;
  logic                out_valid_r;
  logic                advance;
  logic                step_en;

  assign cfg_ready = 1'b1;

  amts_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;
  assign step_en  = in_valid_r && advance;

  always_comb begin
    in_nxt.action           = amts_pkg::action_t'(in_action);
    in_nxt.encoder_diff     = in_encoder_diff;
    in_nxt.start_value      = in_start_value;
    in_nxt.speed            = in_speed;
    in_nxt.blocked          = in_blocked;
    in_nxt.zero_contact     = in_zero_contact;
    in_nxt.traj_control_on  = in_traj_control_on;
    in_nxt.speed_uses_pos   = in_speed_uses_pos;
    in_nxt.speed_pos_target = in_speed_pos_target;
    in_nxt.pos_target       = in_pos_target;
    in_nxt.pos_current      = in_pos_current;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_nxt;
    if (step_en) res_r <= res;
  end

  amts_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .in_word (in_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_valid           = out_valid_r;
  assign out_speed_cmd_valid = res_r.speed_cmd_valid;
  assign out_speed_cmd       = res_r.speed_cmd;
  assign out_pos_cmd_kind    = res_r.pos_cmd_kind;
  assign out_pos_cmd_value   = res_r.pos_cmd_value;
  assign out_mode_cmd        = res_r.mode_cmd;
  assign out_finished        = res_r.finished;
  assign out_pwm_cmd_valid   = res_r.pwm_cmd_valid;
  assign out_pwm_cmd         = res_r.pwm_cmd;
  assign out_traj_state      = res_r.traj_state;
  assign out_motor_position  = res_r.motor_position;

endmodule

`default_nettype wire

// ===== tb/tb_aux_motor_trajectory_sequencer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Auxiliary motor trajectory sequencer testbench
// Drives ticks, start commands and encoder words through the input channel
// with random gaps, stalls the result channel at random and compares every
// result word, field by field, with a cycle-free prediction of the sequencer.
// Runs a directed opening and random trajectories under several register
// settings, the last of them with the extreme wait counts.
// ----------------------------------------------------------------------------

module tb_aux_motor_trajectory_sequencer_top;

  localparam logic [2:0] ACT_UNUSED = 3'd7;

  class trajectory_tracker;
    amts_pkg::cfg_t        regs;
    amts_pkg::traj_mode_t  mode_now;
    logic [15:0]           position;
    logic [9:0]            wait_left;
    logic [31:0]           goto_target;
    logic [15:0]           clamp_pwm;
    logic [15:0]           home_position;
    amts_pkg::res_word_t   expected_cmds[$];
    int                    errors;
    int                    checked;
    int                    finishes;

    function new();
      regs.blk_detect_en      = amts_pkg::RST_BLK_DETECT_EN;
      regs.unblock_backoff    = amts_pkg::RST_UNBLOCK_BACKOFF;
      regs.unblock_ticks      = amts_pkg::RST_UNBLOCK_TICKS;
      regs.done_tolerance     = amts_pkg::RST_DONE_TOLERANCE;
      regs.limit_settle_ticks = amts_pkg::RST_LIMIT_SETTLE_TICKS;
      mode_now      = amts_pkg::TRAJ_DONE;
      position      = '0;
      wait_left     = '0;
      goto_target   = '0;
      clamp_pwm     = '0;
      home_position = '0;
      errors        = 0;
      checked       = 0;
      finishes      = 0;
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    function void write_reg(logic [amts_pkg::CfgIndexW-1:0] idx, logic [15:0] val);
      case (idx)
        amts_pkg::CFG_BLK_DETECT_EN:      regs.blk_detect_en      = val[0];
        amts_pkg::CFG_UNBLOCK_BACKOFF:    regs.unblock_backoff    = val[14:0];
        amts_pkg::CFG_UNBLOCK_TICKS:      regs.unblock_ticks      = val[9:0];
        amts_pkg::CFG_DONE_TOLERANCE:     regs.done_tolerance     = val;
        amts_pkg::CFG_LIMIT_SETTLE_TICKS: regs.limit_settle_ticks = val[9:0];
        default: ;
      endcase
    endfunction

    function void note_word(amts_pkg::in_word_t w);
      amts_pkg::res_word_t e;
      logic [31:0]         pos_err;
      logic [31:0]         mag;
      logic [15:0]         ofs16;
      logic [31:0]         ofs;
      e = '0;
      case (w.action)
        amts_pkg::ACT_TICK: begin
          if (w.traj_control_on) begin
            case (mode_now)
              amts_pkg::TRAJ_SPEED: begin
                if (w.speed_uses_pos && w.speed_pos_target == w.pos_target) begin
                  e.finished = 1'b1;
                  mode_now   = amts_pkg::TRAJ_DONE;
                end
              end
              amts_pkg::TRAJ_GOTO: begin
                if (w.blocked) begin
                  mode_now        = amts_pkg::TRAJ_UNBLOCK;
                  e.pos_cmd_kind  = amts_pkg::POS_OFFSET;
                  e.pos_cmd_value = 32'd0 - {17'd0, regs.unblock_backoff};
                  wait_left       = regs.unblock_ticks;
                end else begin
                  pos_err = w.speed_pos_target - w.pos_current;
                  mag     = pos_err[31] ? 32'd0 - pos_err : pos_err;
                  if (mag < {16'd0, regs.done_tolerance}) begin
                    mode_now   = amts_pkg::TRAJ_DONE;
                    e.finished = 1'b1;
                  end
                end
              end
              amts_pkg::TRAJ_UNBLOCK: begin
                wait_left = wait_left - 10'd1;
                if (wait_left == 10'd0) begin
                  mode_now        = amts_pkg::TRAJ_GOTO;
                  e.pos_cmd_kind  = amts_pkg::POS_ABS;
                  e.pos_cmd_value = goto_target;
                end
              end
              amts_pkg::TRAJ_CLAMP: begin
                if (w.blocked) begin
                  e.mode_cmd      = amts_pkg::MODE_OFF;
                  e.finished      = 1'b1;
                  e.pwm_cmd_valid = 1'b1;
                  e.pwm_cmd       = clamp_pwm;
                  mode_now        = amts_pkg::TRAJ_DONE;
                end
              end
              amts_pkg::TRAJ_ZERO_SEEK: begin
                if (w.zero_contact) mode_now = amts_pkg::TRAJ_ZERO_ON;
              end
              amts_pkg::TRAJ_ZERO_ON: begin
                if (!w.zero_contact) begin
                  e.speed_cmd_valid = 1'b1;
                  e.speed_cmd       = 8'd0;
                  e.finished        = 1'b1;
                  position          = home_position;
                  mode_now          = amts_pkg::TRAJ_DONE;
                end
              end
              amts_pkg::TRAJ_LIMIT: begin
                if (w.blocked) begin
                  e.mode_cmd      = amts_pkg::MODE_TRAJ_ONLY;
                  e.pwm_cmd_valid = 1'b1;
                  e.pwm_cmd       = 16'd0;
                  mode_now        = amts_pkg::TRAJ_SETTLE;
                  wait_left       = regs.limit_settle_ticks;
                end
              end
              amts_pkg::TRAJ_SETTLE: begin
                wait_left = wait_left - 10'd1;
                if (wait_left == 10'd0) begin
                  e.mode_cmd = amts_pkg::MODE_OFF;
                  e.finished = 1'b1;
                  position   = home_position;
                  mode_now   = amts_pkg::TRAJ_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        amts_pkg::ACT_SPEED: begin
          e.mode_cmd = amts_pkg::MODE_TRAJ;
          mode_now   = amts_pkg::TRAJ_SPEED;
        end
        amts_pkg::ACT_GOTO: begin
          ofs16           = w.start_value[15:0] - position;
          ofs             = {{16{ofs16[15]}}, ofs16};
          mode_now        = amts_pkg::TRAJ_GOTO;
          e.pos_cmd_kind  = amts_pkg::POS_OFFSET;
          e.pos_cmd_value = ofs;
          goto_target     = w.pos_current + ofs;
          e.mode_cmd      = regs.blk_detect_en ? amts_pkg::MODE_TRAJ_BLK
                                               : amts_pkg::MODE_TRAJ;
        end
        amts_pkg::ACT_CLAMP: begin
          mode_now          = amts_pkg::TRAJ_CLAMP;
          clamp_pwm         = w.start_value[15:0];
          e.speed_cmd_valid = 1'b1;
          e.speed_cmd       = w.speed;
          e.mode_cmd        = amts_pkg::MODE_TRAJ_BLK;
        end
        amts_pkg::ACT_FIND_ZERO: begin
          mode_now          = amts_pkg::TRAJ_ZERO_SEEK;
          home_position     = w.start_value[15:0];
          e.speed_cmd_valid = 1'b1;
          e.speed_cmd       = w.speed;
          e.mode_cmd        = amts_pkg::MODE_TRAJ;
        end
        amts_pkg::ACT_FIND_LIMIT: begin
          mode_now          = amts_pkg::TRAJ_LIMIT;
          home_position     = w.start_value[15:0];
          e.speed_cmd_valid = 1'b1;
          e.speed_cmd       = w.speed;
          e.mode_cmd        = amts_pkg::MODE_TRAJ_BLK;
        end
        amts_pkg::ACT_ENCODER: position = position + w.encoder_diff;
        default: ;
      endcase
      e.traj_state     = mode_now;
      e.motor_position = position;
      expected_cmds.push_back(e);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task compare(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h, expected %h", checked, field, got, want));
    endtask

    task check_word(amts_pkg::res_word_t got);
      amts_pkg::res_word_t want;
      if (expected_cmds.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
      end else begin
        want = expected_cmds.pop_front();
        compare("speed_cmd_valid", got.speed_cmd_valid, want.speed_cmd_valid);
        compare("speed_cmd", got.speed_cmd, want.speed_cmd);
        compare("pos_cmd_kind", got.pos_cmd_kind, want.pos_cmd_kind);
        compare("pos_cmd_value", got.pos_cmd_value, want.pos_cmd_value);
        compare("mode_cmd", got.mode_cmd, want.mode_cmd);
        compare("finished", got.finished, want.finished);
        compare("pwm_cmd_valid", got.pwm_cmd_valid, want.pwm_cmd_valid);
        compare("pwm_cmd", got.pwm_cmd, want.pwm_cmd);
        compare("traj_state", got.traj_state, want.traj_state);
        compare("motor_position", got.motor_position, want.motor_position);
        if (want.finished) finishes++;
      end
      checked++;
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [amts_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [amts_pkg::CfgDataW-1:0]  cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [2:0]                     in_action = '0;
  logic signed [15:0]             in_encoder_diff = '0;
  logic signed [16:0]             in_start_value = '0;
  logic signed [7:0]              in_speed = '0;
  logic                           in_blocked = 1'b0;
  logic                           in_zero_contact = 1'b0;
  logic                           in_traj_control_on = 1'b0;
  logic                           in_speed_uses_pos = 1'b0;
  logic signed [31:0]             in_speed_pos_target = '0;
  logic signed [31:0]             in_pos_target = '0;
  logic signed [31:0]             in_pos_current = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           out_speed_cmd_valid;
  logic signed [7:0]              out_speed_cmd;
  logic [1:0]                     out_pos_cmd_kind;
  logic signed [31:0]             out_pos_cmd_value;
  logic [2:0]                     out_mode_cmd;
  logic                           out_finished;
  logic                           out_pwm_cmd_valid;
  logic signed [15:0]             out_pwm_cmd;
  logic [3:0]                     out_traj_state;
  logic [15:0]                    out_motor_position;

  trajectory_tracker sb = new();
  int words_sent = 0;
  int reg_loads = 0;

  aux_motor_trajectory_sequencer_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_encoder_diff     (in_encoder_diff),
    .in_start_value      (in_start_value),
    .in_speed            (in_speed),
    .in_blocked          (in_blocked),
    .in_zero_contact     (in_zero_contact),
    .in_traj_control_on  (in_traj_control_on),
    .in_speed_uses_pos   (in_speed_uses_pos),
    .in_speed_pos_target (in_speed_pos_target),
    .in_pos_target       (in_pos_target),
    .in_pos_current      (in_pos_current),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_speed_cmd_valid (out_speed_cmd_valid),
    .out_speed_cmd       (out_speed_cmd),
    .out_pos_cmd_kind    (out_pos_cmd_kind),
    .out_pos_cmd_value   (out_pos_cmd_value),
    .out_mode_cmd        (out_mode_cmd),
    .out_finished        (out_finished),
    .out_pwm_cmd_valid   (out_pwm_cmd_valid),
    .out_pwm_cmd         (out_pwm_cmd),
    .out_traj_state      (out_traj_state),
    .out_motor_position  (out_motor_position)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic amts_pkg::in_word_t rand_word();
    amts_pkg::in_word_t w;
    int sv;
    w.action           = amts_pkg::action_t'($urandom_range(amts_pkg::ACT_TICK, ACT_UNUSED));
    w.encoder_diff     = 16'($urandom);
    sv                 = $urandom_range(0, 98303) - 32768;
    w.start_value      = sv[16:0];
    w.speed            = 8'($urandom);
    w.blocked          = 1'($urandom);
    w.zero_contact     = 1'($urandom);
    w.traj_control_on  = 1'($urandom);
    w.speed_uses_pos   = 1'($urandom);
    w.speed_pos_target = rand32();
    w.pos_target       = rand32();
    w.pos_current      = rand32();
    return w;
  endfunction

  function automatic amts_pkg::in_word_t tick_word(bit ctl, bit blk, bit zc);
    amts_pkg::in_word_t w;
    w                 = rand_word();
    w.action          = amts_pkg::ACT_TICK;
    w.traj_control_on = ctl;
    w.blocked         = blk;
    w.zero_contact    = zc;
    return w;
  endfunction

  // Builds a tick that is likely to move the predicted trajectory along.
  function automatic amts_pkg::in_word_t steer_tick();
    amts_pkg::in_word_t w;
    int t;
    int d;
    w = tick_word($urandom_range(0, 9) != 0, $urandom_range(0, 5) == 0, 1'($urandom));
    case (sb.mode_now)
      amts_pkg::TRAJ_SPEED: begin
        if ($urandom_range(0, 2) == 0) w.pos_target = w.speed_pos_target;
      end
      amts_pkg::TRAJ_GOTO: begin
        if ($urandom_range(0, 2) == 0) begin
          t = int'(sb.regs.done_tolerance);
          if ($urandom_range(0, 3) == 0) d = t - int'($urandom_range(0, 1));
          else d = int'($urandom_range(0, t));
          if ($urandom_range(0, 1) == 1) d = -d;
          w.speed_pos_target = w.pos_current + d;
        end
      end
      amts_pkg::TRAJ_ZERO_SEEK: w.zero_contact = ($urandom_range(0, 2) == 0);
      amts_pkg::TRAJ_ZERO_ON:   w.zero_contact = ($urandom_range(0, 2) != 0);
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(input amts_pkg::in_word_t w);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_action           <= w.action;
    in_encoder_diff     <= w.encoder_diff;
    in_start_value      <= w.start_value;
    in_speed            <= w.speed;
    in_blocked          <= w.blocked;
    in_zero_contact     <= w.zero_contact;
    in_traj_control_on  <= w.traj_control_on;
    in_speed_uses_pos   <= w.speed_uses_pos;
    in_speed_pos_target <= w.speed_pos_target;
    in_pos_target       <= w.pos_target;
    in_pos_current      <= w.pos_current;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_regs(input bit hb, input int backoff, input int ticks,
                           input int tol, input int settle);
    logic [amts_pkg::CfgIndexW-1:0] idx[5];
    logic [15:0]                    val[5];
    idx = '{amts_pkg::CFG_BLK_DETECT_EN, amts_pkg::CFG_UNBLOCK_BACKOFF,
            amts_pkg::CFG_UNBLOCK_TICKS, amts_pkg::CFG_DONE_TOLERANCE,
            amts_pkg::CFG_LIMIT_SETTLE_TICKS};
    val = '{16'(hb), 16'(backoff), 16'(ticks), 16'(tol), 16'(settle)};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
    reg_loads++;
  endtask

  task automatic drive_trajectory(input amts_pkg::action_t start, input int max_ticks);
    amts_pkg::in_word_t w;
    int n;
    w        = rand_word();
    w.action = start;
    send_word(w);
    n = 0;
    while (sb.mode_now != amts_pkg::TRAJ_DONE && n < max_ticks) begin
      if ($urandom_range(0, 9) == 0) begin
        w        = rand_word();
        w.action = amts_pkg::ACT_ENCODER;
      end else begin
        w = steer_tick();
      end
      send_word(w);
      n++;
    end
  endtask

  task automatic random_phase(input int budget);
    int stop_at;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0)
        send_word(rand_word());
      else
        drive_trajectory(amts_pkg::action_t'($urandom_range(amts_pkg::ACT_SPEED,
                                                            amts_pkg::ACT_FIND_LIMIT)), 40);
    end
  endtask

  task automatic directed_opening();
    amts_pkg::in_word_t w;
    w = rand_word(); w.action = amts_pkg::action_t'(ACT_UNUSED); send_word(w);
    w = rand_word(); w.action = amts_pkg::ACT_ENCODER; w.encoder_diff = 16'h7FFF;
    send_word(w);
    w = rand_word(); w.action = amts_pkg::ACT_ENCODER; w.encoder_diff = 16'h8000;
    send_word(w);
    w = rand_word(); w.action = amts_pkg::ACT_SPEED; w.traj_control_on = 1'b0;
    send_word(w);
    w = tick_word(1'b0, 1'b0, 1'b0); w.speed_uses_pos = 1'b1;
    w.pos_target = w.speed_pos_target; send_word(w);
    w = tick_word(1'b1, 1'b0, 1'b0); w.speed_uses_pos = 1'b0;
    w.pos_target = w.speed_pos_target; send_word(w);
    w = tick_word(1'b1, 1'b0, 1'b0); w.speed_uses_pos = 1'b1;
    w.pos_target = w.speed_pos_target; send_word(w);
    w = rand_word(); w.action = amts_pkg::ACT_GOTO; w.start_value = 17'h00000;
    w.pos_current = 32'h7FFF_FFFF; send_word(w);
    w = tick_word(1'b1, 1'b0, 1'b0); w.speed_pos_target = 32'h7FFF_FFFF;
    w.pos_current = 32'hFFFF_FFFF; send_word(w);
    w = tick_word(1'b1, 1'b0, 1'b0); w.pos_current = 32'h8000_0000;
    w.speed_pos_target = 32'h8000_0000 + 32'd300; send_word(w);
    w = tick_word(1'b1, 1'b0, 1'b0); w.pos_current = 32'h0000_0100;
    w.speed_pos_target = 32'h0000_0100 - 32'd299; send_word(w);
    w = rand_word(); w.action = amts_pkg::ACT_GOTO; w.start_value = 17'h18000;
    send_word(w);
    w = tick_word(1'b1, 1'b1, 1'b0); send_word(w);
    w = rand_word(); w.action = amts_pkg::ACT_CLAMP; w.start_value = 17'h18000;
    w.speed = 8'h80; send_word(w);
    w = tick_word(1'b1, 1'b0, 1'b1); send_word(w);
    w = tick_word(1'b1, 1'b1, 1'b0); send_word(w);
    w = rand_word(); w.action = amts_pkg::ACT_FIND_ZERO; w.start_value = 17'h0FFFF;
    w.speed = 8'h7F; send_word(w);
    w = tick_word(1'b1, 1'b1, 1'b0); send_word(w);
    w = tick_word(1'b1, 1'b0, 1'b1); send_word(w);
    w = tick_word(1'b0, 1'b0, 1'b0); send_word(w);
    w = tick_word(1'b1, 1'b0, 1'b1); send_word(w);
    w = tick_word(1'b1, 1'b0, 1'b0); send_word(w);
    w = rand_word(); w.action = amts_pkg::ACT_FIND_LIMIT; w.start_value = 17'h01234;
    w.speed = 8'h00; send_word(w);
    w = tick_word(1'b1, 1'b1, 1'b0); send_word(w);
    w = rand_word(); w.action = amts_pkg::action_t'(ACT_UNUSED); send_word(w);
  endtask

  initial begin : result_ready
    int g;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    amts_pkg::res_word_t r;
    if (rst_n && out_valid && out_ready) begin
      r.speed_cmd_valid = out_speed_cmd_valid;
      r.speed_cmd       = out_speed_cmd;
      r.pos_cmd_kind    = amts_pkg::pos_kind_t'(out_pos_cmd_kind);
      r.pos_cmd_value   = out_pos_cmd_value;
      r.mode_cmd        = amts_pkg::mode_cmd_t'(out_mode_cmd);
      r.finished        = out_finished;
      r.pwm_cmd_valid   = out_pwm_cmd_valid;
      r.pwm_cmd         = out_pwm_cmd;
      r.traj_state      = amts_pkg::traj_mode_t'(out_traj_state);
      r.motor_position  = out_motor_position;
      sb.check_word(r);
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_opening();
    load_regs(1'b1, 0, 1, 0, 1);
    random_phase(200);
    load_regs(1'b0, 32767, 2, 65535, 3);
    random_phase(200);
    repeat (2) begin
      load_regs(1'($urandom_range(0, 1)), $urandom_range(0, 32767), $urandom_range(1, 9),
                $urandom_range(0, 4000), $urandom_range(1, 9));
      random_phase(200);
    end
    load_regs(1'b1, $urandom_range(0, 32767), 1023, $urandom_range(100, 3000), 0);
    random_phase(200);
    wait_idle();
    $display("Sent %0d words under %0d register settings besides reset.", words_sent,
             reg_loads);
    $display("Checked %0d result words, %0d of them marking a trajectory finished.",
             sb.checked, sb.finishes);
    if (sb.errors == 0) begin
      $display("tb_aux_motor_trajectory_sequencer_top: clean");
    end else begin
      $display("tb_aux_motor_trajectory_sequencer_top: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("tb_aux_motor_trajectory_sequencer_top: errors");
    $finish;
  end

endmodule
